[design/second_difference_peak_search_top_assert.svh]
`ifndef SECOND_DIFFERENCE_PEAK_SEARCH_TOP_ASSERT_SVH
`define SECOND_DIFFERENCE_PEAK_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define SDPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define SDPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sdps_pkg.sv]
package sdps_pkg;

	localparam int CHANNEL_BITS_DEF = 16;
	localparam int SAMPLE_BITS_DEF  = 32;

	localparam int CFG_ADDR_BITS = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam int SIGMA_BITS    = 4;

	localparam logic [CFG_DATA_BITS-1:0] FIRST_CHANNEL_RST = 16'd3;
	localparam logic [SIGMA_BITS-1:0]    SIGMA_FACTOR_RST  = 4'd4;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_FIRST_CHANNEL = 1'b0,
		CFG_SIGMA_FACTOR  = 1'b1
	} cfg_reg_t;

	// Channel classes: above deviation, positive, non-positive.
	typedef enum logic [1:0] {
		CLASS_HIGH   = 2'd1,
		CLASS_POS    = 2'd2,
		CLASS_NONPOS = 2'd3
	} class_t;

	// Control from the tracking logic to the input and result registers.
	typedef struct packed {
		logic take;         // the word in the input register is consumed
		logic load_result;  // a peak is written into the result register
	} track_ctl_t;

endpackage

[design/second_difference_peak_search_top.sv]
// Channel      | Direction | Handshake                  | Contents
// s_axis       | in        | s_axis_tvalid/s_axis_tready | one spectrum channel word
// m_axis       | out       | m_axis_tvalid/m_axis_tready | one found peak word
// cfg          | in        | cfg_we                     | first_channel, sigma_factor
//
// One word is taken every cycle while no held result stalls it. A word is classified as it
// enters the input register, and its peak, if it completes one, goes from there into the
// result register, from which it can be taken downstream.
// Reset clears the marks and minima, sets the channel counter to 3 and sigma_factor to 4.
// A held result stalls only a word that completes another peak; s_axis_tready follows
// m_axis_tready through logic.
module second_difference_peak_search_top #(
	parameter int CHANNEL_BITS = sdps_pkg::CHANNEL_BITS_DEF,
	parameter int SAMPLE_BITS  = sdps_pkg::SAMPLE_BITS_DEF,
	localparam int IN_BITS  = ((2 * SAMPLE_BITS - 1 + 7) / 8) * 8,
	localparam int OUT_BITS = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// second_difference, deviation, zero fill
	input  logic [IN_BITS-1:0]                 s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// peak_start, peak_center, peak_end, zero fill
	output logic [OUT_BITS-1:0]                m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [sdps_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [sdps_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	logic signed [SAMPLE_BITS-1:0] second_difference;
	logic        [SAMPLE_BITS-2:0] deviation;

	sdps_pkg::track_ctl_t          ctl;
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sd_s1;
	logic        [SAMPLE_BITS-2:0] dev_s1;
	sdps_pkg::class_t              cls_s1;
	logic                          out_free;
	logic [CHANNEL_BITS-1:0]       res_start, res_center, res_end;
	logic [CHANNEL_BITS-1:0]       peak_start, peak_center, peak_end;

	// Unpack the input word; the fill bits above the deviation are ignored.
	assign second_difference = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
	assign deviation         = s_axis_tdata[2*SAMPLE_BITS-2:SAMPLE_BITS];

	sdps_in_stage #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_in (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.second_difference (second_difference),
		.deviation         (deviation),
		.ctl               (ctl),
		.valid_s1          (valid_s1),
		.sd_s1             (sd_s1),
		.dev_s1            (dev_s1),
		.cls_s1            (cls_s1)
	);

	sdps_track #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.valid_s1   (valid_s1),
		.sd_s1      (sd_s1),
		.dev_s1     (dev_s1),
		.cls_s1     (cls_s1),
		.out_free   (out_free),
		.ctl        (ctl),
		.res_start  (res_start),
		.res_center (res_center),
		.res_end    (res_end)
	);

	sdps_out_reg #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.res_start    (res_start),
		.res_center   (res_center),
		.res_end      (res_end),
		.out_ready    (m_axis_tready),
		.out_free     (out_free),
		.valid_s2     (m_axis_tvalid),
		.pk_start_s2  (peak_start),
		.pk_center_s2 (peak_center),
		.pk_end_s2    (peak_end)
	);

	assign m_axis_tdata = OUT_BITS'({peak_end, peak_center, peak_start});

endmodule

[design/sdps_in_stage.sv]
// Input register: holds one word and classifies it against its deviation.
module sdps_in_stage #(
	parameter int SAMPLE_BITS = sdps_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] second_difference,
	input  logic        [SAMPLE_BITS-2:0] deviation,
	input  sdps_pkg::track_ctl_t          ctl,
	output logic                          valid_s1,
	output logic signed [SAMPLE_BITS-1:0] sd_s1,
	output logic        [SAMPLE_BITS-2:0] dev_s1,
	output sdps_pkg::class_t              cls_s1
);

	logic             accept;
	sdps_pkg::class_t cls;

	assign in_ready = !valid_s1 || ctl.take;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (second_difference > $signed({1'b0, deviation})) begin
			cls = sdps_pkg::CLASS_HIGH;
		end else if (!second_difference[SAMPLE_BITS-1] && (second_difference != '0)) begin
			cls = sdps_pkg::CLASS_POS;
		end else begin
			cls = sdps_pkg::CLASS_NONPOS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ctl.take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sd_s1  <= second_difference;
			dev_s1 <= deviation;
			cls_s1 <= cls;
		end
	end

endmodule

[design/sdps_track.sv]
// Mark tracking, running minimum, commit and significance test for one word.
module sdps_track #(
	parameter int CHANNEL_BITS = sdps_pkg::CHANNEL_BITS_DEF,
	parameter int SAMPLE_BITS  = sdps_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sdps_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [sdps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                valid_s1,
	input  logic signed [SAMPLE_BITS-1:0]       sd_s1,
	input  logic        [SAMPLE_BITS-2:0]       dev_s1,
	input  sdps_pkg::class_t                    cls_s1,
	input  logic                                out_free,
	output sdps_pkg::track_ctl_t                ctl,
	output logic [CHANNEL_BITS-1:0]             res_start,
	output logic [CHANNEL_BITS-1:0]             res_center,
	output logic [CHANNEL_BITS-1:0]             res_end
);

	localparam int LIM_BITS = SAMPLE_BITS - 1 + sdps_pkg::SIGMA_BITS;

	logic [CHANNEL_BITS-1:0]             chan_q;
	logic [sdps_pkg::SIGMA_BITS-1:0]     sigma_q;
	sdps_pkg::class_t                    prev_cls_q;
	logic [CHANNEL_BITS-1:0]             rise_q, lobe_q, valley_q;
	logic [CHANNEL_BITS-1:0]             min_idx_q;
	logic signed [SAMPLE_BITS-1:0]       min_val_q;
	logic [SAMPLE_BITS-2:0]              min_dev_q;
	logic [CHANNEL_BITS-1:0]             com_idx_q;
	logic signed [SAMPLE_BITS-1:0]       com_val_q;
	logic [SAMPLE_BITS-2:0]              com_dev_q;

	logic [CHANNEL_BITS-1:0]             prev_ch;
	logic [CHANNEL_BITS-1:0]             rise_n, lobe_n, valley_n;
	logic                                restart;
	logic [CHANNEL_BITS-1:0]             min_idx_n;
	logic signed [SAMPLE_BITS-1:0]       min_val_n;
	logic [SAMPLE_BITS-2:0]              min_dev_n;
	logic                                run_end;
	logic                                commit;
	logic [CHANNEL_BITS-1:0]             com_idx_c;
	logic signed [SAMPLE_BITS-1:0]       com_val_c;
	logic [SAMPLE_BITS-2:0]              com_dev_c;
	logic [SAMPLE_BITS-1:0]              mag;
	logic [LIM_BITS-1:0]                 limit;
	logic                                pass;

	assign prev_ch = chan_q - CHANNEL_BITS'(1);

	// Class transitions set the marks; a new valley restarts the minimum search.
	always_comb begin
		rise_n   = rise_q;
		lobe_n   = lobe_q;
		valley_n = valley_q;
		restart  = 1'b0;
		case (prev_cls_q)
			sdps_pkg::CLASS_HIGH: begin
				if (cls_s1 == sdps_pkg::CLASS_NONPOS) begin
					valley_n = chan_q;
					lobe_n   = prev_ch;
					restart  = 1'b1;
				end else if (cls_s1 == sdps_pkg::CLASS_POS) begin
					lobe_n = prev_ch;
				end
			end
			sdps_pkg::CLASS_POS: begin
				if (cls_s1 == sdps_pkg::CLASS_NONPOS) begin
					valley_n = chan_q;
					restart  = 1'b1;
				end else if (cls_s1 == sdps_pkg::CLASS_HIGH) begin
					rise_n = chan_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Only a strictly smaller value replaces the minimum, so the first one wins.
	always_comb begin
		min_idx_n = restart ? '0 : min_idx_q;
		min_val_n = restart ? '0 : min_val_q;
		min_dev_n = restart ? '0 : min_dev_q;
		if (sd_s1 < min_val_n) begin
			min_idx_n = chan_q;
			min_val_n = sd_s1;
			min_dev_n = dev_s1;
		end
	end

	assign run_end = (prev_cls_q == sdps_pkg::CLASS_NONPOS) &&
	                 (cls_s1 != sdps_pkg::CLASS_NONPOS);
	assign commit  = run_end && (rise_n != '0) && (lobe_n != '0) && (valley_n != '0) &&
	                 (prev_ch != '0) && min_val_n[SAMPLE_BITS-1];

	assign com_idx_c = commit ? min_idx_n : com_idx_q;
	assign com_val_c = commit ? min_val_n : com_val_q;
	assign com_dev_c = commit ? min_dev_n : com_dev_q;

	// Magnitude of the most negative value still fits in SAMPLE_BITS unsigned.
	assign mag   = com_val_c[SAMPLE_BITS-1] ? SAMPLE_BITS'(-com_val_c) : SAMPLE_BITS'(com_val_c);
	assign limit = LIM_BITS'(sigma_q) * LIM_BITS'(com_dev_c);
	assign pass  = run_end && (LIM_BITS'(mag) > limit);

	assign ctl.take        = valid_s1 && (!pass || out_free);
	assign ctl.load_result = valid_s1 && pass && out_free;

	assign res_start  = valley_n;
	assign res_center = com_idx_c;
	assign res_end    = prev_ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHANNEL_BITS'(sdps_pkg::FIRST_CHANNEL_RST);
		end else if (cfg_we && (sdps_pkg::cfg_reg_t'(cfg_addr) == sdps_pkg::CFG_FIRST_CHANNEL)) begin
			chan_q <= CHANNEL_BITS'(cfg_data);
		end else if (ctl.take) begin
			chan_q <= chan_q + CHANNEL_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= sdps_pkg::SIGMA_FACTOR_RST;
		end else if (cfg_we) begin
			unique case (sdps_pkg::cfg_reg_t'(cfg_addr))
				sdps_pkg::CFG_SIGMA_FACTOR:  sigma_q <= cfg_data[sdps_pkg::SIGMA_BITS-1:0];
				sdps_pkg::CFG_FIRST_CHANNEL: sigma_q <= sigma_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cls_q <= sdps_pkg::CLASS_NONPOS;
			rise_q     <= '0;
			lobe_q     <= '0;
			valley_q   <= '0;
			min_idx_q  <= '0;
			min_val_q  <= '0;
			min_dev_q  <= '0;
			com_idx_q  <= '0;
			com_val_q  <= '0;
			com_dev_q  <= '0;
		end else if (ctl.take) begin
			prev_cls_q <= cls_s1;
			if (pass) begin
				rise_q    <= '0;
				lobe_q    <= '0;
				valley_q  <= '0;
				min_idx_q <= '0;
				min_val_q <= '0;
				min_dev_q <= '0;
				com_idx_q <= '0;
				com_val_q <= '0;
				com_dev_q <= '0;
			end else begin
				rise_q    <= rise_n;
				lobe_q    <= lobe_n;
				valley_q  <= valley_n;
				min_idx_q <= min_idx_n;
				min_val_q <= min_val_n;
				min_dev_q <= min_dev_n;
				com_idx_q <= com_idx_c;
				com_val_q <= com_val_c;
				com_dev_q <= com_dev_c;
			end
		end
	end

endmodule

[design/sdps_out_reg.sv]
// Result register: holds one peak until the downstream side takes it.
module sdps_out_reg #(
	parameter int CHANNEL_BITS = sdps_pkg::CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sdps_pkg::track_ctl_t    ctl,
	input  logic [CHANNEL_BITS-1:0] res_start,
	input  logic [CHANNEL_BITS-1:0] res_center,
	input  logic [CHANNEL_BITS-1:0] res_end,
	input  logic                    out_ready,
	output logic                    out_free,
	output logic                    valid_s2,
	output logic [CHANNEL_BITS-1:0] pk_start_s2,
	output logic [CHANNEL_BITS-1:0] pk_center_s2,
	output logic [CHANNEL_BITS-1:0] pk_end_s2
);

	assign out_free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.load_result) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_result) begin
			pk_start_s2  <= res_start;
			pk_center_s2 <= res_center;
			pk_end_s2    <= res_end;
		end
	end

endmodule

[design/sdps_checker.sv]
`include "second_difference_peak_search_top_assert.svh"

// Watches the top-level ports of the peak search.
module sdps_checker #(
	parameter int OUT_BITS = 48
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OUT_BITS-1:0] m_axis_tdata
);

	// A stalled result keeps its word.
	`SDPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

	// With the result register empty, nothing can hold the input back.
	`SDPS_ASSERT_SAME(a_in_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty result register")

	// A fresh result comes from an accepted word that passed through the input register.
	`SDPS_ASSERT_SAME(a_result_latency, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without matching input word")

endmodule

bind second_difference_peak_search_top sdps_checker #(
	.OUT_BITS(OUT_BITS)
) u_sdps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
